### sv/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

   localparam int WIDTH        = 256;
   localparam int HEIGHT       = 192;
   localparam int BURST_PIXELS = 32;
   localparam int PALETTE_SIZE = 32;

   localparam int COL_W     = $clog2(WIDTH);
   localparam int LINE_W    = $clog2(HEIGHT + 1);
   localparam int BURST_W   = (BURST_PIXELS > 2) ? $clog2(BURST_PIXELS) : 1;
   localparam int PAL_IDX_W = (PALETTE_SIZE > 2) ? $clog2(PALETTE_SIZE) : 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   localparam logic [5:0] BITS_COMMAND = 6'd8;
   localparam logic [5:0] BITS_SINGLE  = 6'd16;
   localparam logic [5:0] BITS_FULL    = 6'd32;

   localparam logic [8:0] X_START_RESET = 9'd32;
   localparam logic [7:0] Y_START_RESET = 8'd24;

   typedef enum logic [1:0] {
      FUNC_PALETTE = 2'd0,
      FUNC_START   = 2'd1,
      FUNC_PIXEL   = 2'd2
   } func_type;

   typedef enum logic {
      REG_X_START = 1'b0,
      REG_Y_START = 1'b1
   } reg_index_type;

   typedef enum logic {
      KIND_WORD  = 1'b0,
      KIND_START = 1'b1
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type kind;
      logic [31:0]    word;
      logic [5:0]     valid_bits;
      logic           end_of_transfer;
      logic           frame_done;
      logic [8:0]     x_start;
      logic [7:0]     y_start;
   } entry_type;

endpackage

### sv/palette_pixel_spi_display_streamer.sv
`timescale 1ns / 1ps

// Turns palette-indexed pixels into packed 32-bit serial words for an RGB565
// display controller. One input transaction is taken per clock cycle while the
// internal queue has room. A palette write gives no word, and a pixel gives at
// most one: every second pixel makes a word holding the pair, and a lone pixel
// that closes a transfer makes a word of its own. A start transaction gives
// five set-up words that the back-end sequencer sends one per cycle while the
// output is not stalled, so a start holds the output until all five are out. A
// four-entry queue between the front end (palette, position counters, pairing)
// and the back end lets the input keep flowing while the output is stalled,
// until the queue fills. A word is written into the queue when its transaction
// is taken and then loaded into the output register, which reloads in the
// same cycle its word is taken, so words leave back to back.

module palette_pixel_spi_display_streamer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_pal_slot,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_pixel_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_spi_word,
   output logic [5:0]  rsp_valid_bits,
   output logic        rsp_is_command,
   output logic        rsp_end_of_transfer,
   output logic        rsp_frame_done,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   logic               queue_full;
   logic               push;
   pps_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   pps_pkg::entry_type head_entry;

   pps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_pal_slot   (req_pal_slot),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_pixel_code (req_pixel_code),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   pps_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   pps_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_spi_word        (rsp_spi_word),
      .rsp_valid_bits      (rsp_valid_bits),
      .rsp_is_command      (rsp_is_command),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_last            (rsp_last)
   );

endmodule

### sv/pps_front.sv
`timescale 1ns / 1ps

module pps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [4:0]         req_pal_slot,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_pixel_code,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [8:0]         csr_data,
   input  logic               queue_full,
   output logic               push,
   output pps_pkg::entry_type push_entry
);

   logic [15:0]                  palette_ff [pps_pkg::PALETTE_SIZE];
   logic [8:0]                   x_start_ff;
   logic [7:0]                   y_start_ff;
   logic [pps_pkg::COL_W-1:0]    col_ff, col_in;
   logic [pps_pkg::LINE_W-1:0]   line_ff, line_in;
   logic [pps_pkg::BURST_W-1:0]  burst_ff, burst_in;
   logic [15:0]                  held_ff, held_in;

   logic                          accept;
   logic                          pal_write;
   logic [pps_pkg::PAL_IDX_W-1:0] wr_idx;
   logic [pps_pkg::PAL_IDX_W-1:0] rd_idx;
   logic [15:0]                   colour;
   logic [15:0]                   new_colour;
   logic                          active;
   logic [pps_pkg::COL_W:0]       next_col;
   logic                          line_end;
   logic                          closes;
   logic                          done;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign wr_idx     = pps_pkg::PAL_IDX_W'(req_pal_slot);
   assign rd_idx     = pps_pkg::PAL_IDX_W'(req_pixel_code[4:0]);
   assign new_colour = {req_red[7:3], req_green[7:2], req_blue[7:3]};
   assign colour     = (9'(req_pixel_code[4:0]) < 9'(pps_pkg::PALETTE_SIZE)) ?
                       palette_ff[rd_idx] : 16'd0;

   assign active   = line_ff < pps_pkg::LINE_W'(pps_pkg::HEIGHT);
   assign next_col = (pps_pkg::COL_W+1)'(col_ff) + (pps_pkg::COL_W+1)'(1);
   assign line_end = next_col >= (pps_pkg::COL_W+1)'(pps_pkg::WIDTH);
   assign closes   = line_end ||
                     (burst_ff == pps_pkg::BURST_W'(pps_pkg::BURST_PIXELS - 1));
   assign done     = line_end &&
                     ((pps_pkg::LINE_W+1)'(line_ff) + (pps_pkg::LINE_W+1)'(1) >=
                      (pps_pkg::LINE_W+1)'(pps_pkg::HEIGHT));

   always_comb begin
      col_in     = col_ff;
      line_in    = line_ff;
      burst_in   = burst_ff;
      held_in    = held_ff;
      pal_write  = 1'b0;
      push       = 1'b0;
      push_entry = '0;
      push_entry.kind    = pps_pkg::KIND_WORD;
      push_entry.x_start = x_start_ff;
      push_entry.y_start = y_start_ff;
      if (accept) begin
         case (req_func)
            pps_pkg::FUNC_PALETTE: begin
               pal_write = 9'(req_pal_slot) < 9'(pps_pkg::PALETTE_SIZE);
            end
            pps_pkg::FUNC_START: begin
               push            = 1'b1;
               push_entry.kind = pps_pkg::KIND_START;
               col_in          = '0;
               line_in         = '0;
               burst_in        = '0;
               held_in         = '0;
            end
            pps_pkg::FUNC_PIXEL: begin
               if (active) begin
                  push_entry.frame_done = done;
                  if (!burst_ff[0]) begin
                     if (closes) begin
                        push                       = 1'b1;
                        push_entry.word            = {colour, 16'd0};
                        push_entry.valid_bits      = pps_pkg::BITS_SINGLE;
                        push_entry.end_of_transfer = 1'b1;
                     end else begin
                        held_in = colour;
                     end
                  end else begin
                     push                       = 1'b1;
                     push_entry.word            = {held_ff, colour};
                     push_entry.valid_bits      = pps_pkg::BITS_FULL;
                     push_entry.end_of_transfer = closes;
                  end
                  if (line_end) begin
                     col_in   = '0;
                     line_in  = line_ff + pps_pkg::LINE_W'(1);
                     burst_in = '0;
                  end else begin
                     col_in   = next_col[pps_pkg::COL_W-1:0];
                     burst_in = closes ? '0 : burst_ff + pps_pkg::BURST_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pps_pkg::PALETTE_SIZE; i++) begin
            palette_ff[i] <= 16'd0;
         end
         x_start_ff <= pps_pkg::X_START_RESET;
         y_start_ff <= pps_pkg::Y_START_RESET;
         col_ff     <= '0;
         line_ff    <= pps_pkg::LINE_W'(pps_pkg::HEIGHT);
         burst_ff   <= '0;
         held_ff    <= '0;
      end else begin
         if (pal_write) begin
            palette_ff[wr_idx] <= new_colour;
         end
         if (csr_write) begin
            case (csr_index)
               pps_pkg::REG_X_START: x_start_ff <= csr_data;
               pps_pkg::REG_Y_START: y_start_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         col_ff   <= col_in;
         line_ff  <= line_in;
         burst_ff <= burst_in;
         held_ff  <= held_in;
      end
   end

endmodule

### sv/pps_fifo.sv
`timescale 1ns / 1ps

module pps_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pps_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pps_pkg::entry_type head_entry
);

   pps_pkg::entry_type          slots_ff [pps_pkg::QUEUE_DEPTH];
   logic [pps_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pps_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pps_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign full       = count_ff == pps_pkg::QCNT_W'(pps_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pps_pkg::QPTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + pps_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pps_pkg::QPTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + pps_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + pps_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pps_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/pps_back.sv
`timescale 1ns / 1ps

module pps_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  pps_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_spi_word,
   output logic [5:0]         rsp_valid_bits,
   output logic               rsp_is_command,
   output logic               rsp_end_of_transfer,
   output logic               rsp_frame_done,
   output logic               rsp_last
);

   typedef enum logic [2:0] {
      STEP_COL_CMD,
      STEP_COL_DATA,
      STEP_PAGE_CMD,
      STEP_PAGE_DATA,
      STEP_MEM_CMD
   } step_type;

   step_type    step_ff, step_in;
   logic        valid_ff, valid_in;
   logic [31:0] word_ff, word_in;
   logic [5:0]  bits_ff, bits_in;
   logic        cmd_ff, cmd_in;
   logic        eot_ff, eot_in;
   logic        done_ff, done_in;
   logic        last_ff, last_in;

   logic        load;
   logic [15:0] x_first, x_end, y_first, y_end;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign x_first = 16'(head_entry.x_start);
   assign x_end   = x_first + 16'(pps_pkg::WIDTH - 1);
   assign y_first = 16'(head_entry.y_start);
   assign y_end   = y_first + 16'(pps_pkg::HEIGHT);

   always_comb begin
      step_in  = step_ff;
      valid_in = rsp_stall ? valid_ff : 1'b0;
      word_in  = word_ff;
      bits_in  = bits_ff;
      cmd_in   = cmd_ff;
      eot_in   = eot_ff;
      done_in  = done_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_entry.kind == pps_pkg::KIND_WORD) begin
            pop     = 1'b1;
            word_in = head_entry.word;
            bits_in = head_entry.valid_bits;
            cmd_in  = 1'b0;
            eot_in  = head_entry.end_of_transfer;
            done_in = head_entry.frame_done;
            last_in = 1'b1;
         end else begin
            bits_in = pps_pkg::BITS_COMMAND;
            cmd_in  = 1'b1;
            eot_in  = 1'b1;
            done_in = 1'b0;
            last_in = 1'b0;
            case (step_ff)
               STEP_COL_CMD: begin
                  word_in = {pps_pkg::CMD_COLUMN_SET, 24'd0};
                  step_in = STEP_COL_DATA;
               end
               STEP_COL_DATA: begin
                  word_in = {x_first, x_end};
                  bits_in = pps_pkg::BITS_FULL;
                  cmd_in  = 1'b0;
                  step_in = STEP_PAGE_CMD;
               end
               STEP_PAGE_CMD: begin
                  word_in = {pps_pkg::CMD_PAGE_SET, 24'd0};
                  step_in = STEP_PAGE_DATA;
               end
               STEP_PAGE_DATA: begin
                  word_in = {y_first, y_end};
                  bits_in = pps_pkg::BITS_FULL;
                  cmd_in  = 1'b0;
                  step_in = STEP_MEM_CMD;
               end
               STEP_MEM_CMD: begin
                  word_in = {pps_pkg::CMD_MEMORY_WRITE, 24'd0};
                  last_in = 1'b1;
                  pop     = 1'b1;
                  step_in = STEP_COL_CMD;
               end
               default: begin
                  step_in = STEP_COL_CMD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      bits_ff <= bits_in;
      cmd_ff  <= cmd_in;
      eot_ff  <= eot_in;
      done_ff <= done_in;
      last_ff <= last_in;
      if (reset) begin
         step_ff  <= STEP_COL_CMD;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_spi_word        = word_ff;
   assign rsp_valid_bits      = bits_ff;
   assign rsp_is_command      = cmd_ff;
   assign rsp_end_of_transfer = eot_ff;
   assign rsp_frame_done      = done_ff;
   assign rsp_last            = last_ff;

endmodule
